### rtl/core/dur_pkg.sv
// ----------------------------------------------------------------------------
// dur_pkg
// Shared types, constants and the echo width to distance conversion for the
// dual ultrasonic ranger.
// ----------------------------------------------------------------------------
`default_nettype none

package dur_pkg;

    localparam int COUNT_WIDTH = 20;
    localparam int TRIG_W      = 8;
    localparam int TIMEOUT_W   = 20;
    localparam int CMP_W       = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
    localparam int DIST_W      = 10;
    localparam int COMB_W      = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // distance = floor(width / 58), clamped
    localparam int CM_DIVISOR = 58;
    localparam int CM_MAX     = 999;
    localparam int CM_SCALE   = 1000;
    localparam int CM_LIMIT   = CM_DIVISOR * (CM_MAX + 1);
    localparam int LIM_W      = 16;
    localparam int CM_SHIFT   = 20;
    localparam int CM_RECIP   = ((1 << CM_SHIFT) + CM_DIVISOR - 1) / CM_DIVISOR;
    localparam int RECIP_W    = 15;

    localparam logic [TRIG_W-1:0]    TRIG_RESET = 8'd10;
    localparam logic [TIMEOUT_W-1:0] RISE_RESET = 20'd100000;
    localparam logic [TIMEOUT_W-1:0] FALL_RESET = 20'd1000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIGGER_TICKS = 2'd0,
        REG_RISE_TIMEOUT  = 2'd1,
        REG_FALL_TIMEOUT  = 2'd2
    } dur_reg_t;

    // stream layout
    localparam int IN_W          = 8;
    localparam int IN_START_BIT  = 0;
    localparam int IN_ECHO_A_BIT = 1;
    localparam int IN_ECHO_B_BIT = 2;

    localparam int OUT_W         = 48;
    localparam int OUT_TRIG_A    = 0;
    localparam int OUT_TRIG_B    = 1;
    localparam int OUT_BUSY      = 2;
    localparam int OUT_DONE      = 3;
    localparam int OUT_DIST_A    = 4;
    localparam int OUT_DIST_B    = OUT_DIST_A + DIST_W;
    localparam int OUT_COMB      = OUT_DIST_B + DIST_W;
    localparam int OUT_USED      = OUT_COMB + COMB_W;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_TRIG_A = 3'd1,
        PH_WAIT_A = 3'd2,
        PH_MEAS_A = 3'd3,
        PH_TRIG_B = 3'd4,
        PH_WAIT_B = 3'd5,
        PH_MEAS_B = 3'd6
    } dur_phase_t;

    typedef struct packed {
        logic [TRIG_W-1:0]    trigger_ticks;
        logic [TIMEOUT_W-1:0] rise_timeout;
        logic [TIMEOUT_W-1:0] fall_timeout;
    } dur_cfg_t;

    typedef struct packed {
        logic start_request;
        logic echo_a;
        logic echo_b;
    } dur_item_t;

    typedef struct packed {
        logic              trigger_a;
        logic              trigger_b;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] distance_a;
        logic [DIST_W-1:0] distance_b;
        logic [COMB_W-1:0] combined_reading;
    } dur_res_t;

    function automatic logic [DIST_W-1:0] width_to_cm(input logic [COUNT_WIDTH-1:0] w);
        logic [LIM_W+RECIP_W-1:0] prod;
        prod = LIM_W'(w) * RECIP_W'(CM_RECIP);
        if (w >= COUNT_WIDTH'(CM_LIMIT))
            return DIST_W'(CM_MAX);
        else
            return prod[CM_SHIFT +: DIST_W];
    endfunction

endpackage

`default_nettype wire

### rtl/core/dur_step.sv
// ----------------------------------------------------------------------------
// dur_step
// One tick of the ranging sequence: next phase, counter and stored distance,
// and the result for this tick.
// ----------------------------------------------------------------------------
`default_nettype none

module dur_step (
    input  dur_pkg::dur_phase_t             phase,
    input  logic [dur_pkg::COUNT_WIDTH-1:0] count,
    input  logic [dur_pkg::DIST_W-1:0]      first_distance,
    input  dur_pkg::dur_cfg_t               cfg,
    input  dur_pkg::dur_item_t              item,
    output dur_pkg::dur_phase_t             phase_next,
    output logic [dur_pkg::COUNT_WIDTH-1:0] count_next,
    output logic [dur_pkg::DIST_W-1:0]      first_distance_next,
    output dur_pkg::dur_res_t               res
);
    import dur_pkg::*;

    logic                   side_a;
    logic                   echo;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [COUNT_WIDTH-1:0] meas_cnt;
    logic [COUNT_WIDTH-1:0] width;
    logic                   meas_hit;
    logic [DIST_W-1:0]      cm_meas;
    logic                   end_now;
    logic [DIST_W-1:0]      end_cm;
    logic                   done;
    logic [COMB_W-1:0]      comb;

    assign side_a   = (phase == PH_TRIG_A) || (phase == PH_WAIT_A) || (phase == PH_MEAS_A);
    assign echo     = side_a ? item.echo_a : item.echo_b;
    assign cnt_inc  = (count == CNT_MAX) ? count : count + 1'b1;
    assign meas_cnt = ((phase == PH_WAIT_A) || (phase == PH_WAIT_B))
                      ? COUNT_WIDTH'(1) : cnt_inc;
    assign meas_hit = (CMP_W'(meas_cnt) >= CMP_W'(cfg.fall_timeout)) || (meas_cnt == CNT_MAX);
    assign width    = (((phase == PH_MEAS_A) || (phase == PH_MEAS_B)) && !echo)
                      ? count : meas_cnt;
    assign cm_meas  = width_to_cm(width);

    // next state
    always_comb
    begin
        phase_next          = phase;
        count_next          = count;
        first_distance_next = first_distance;
        end_now             = 1'b0;
        end_cm              = cm_meas;
        unique case (phase)
            PH_IDLE:
            begin
                if (item.start_request)
                begin
                    phase_next = PH_TRIG_A;
                    count_next = '0;
                end
            end
            PH_TRIG_A, PH_TRIG_B:
            begin
                count_next = cnt_inc;
                if (cnt_inc >= COUNT_WIDTH'(cfg.trigger_ticks))
                begin
                    phase_next = (phase == PH_TRIG_A) ? PH_WAIT_A : PH_WAIT_B;
                    count_next = '0;
                end
            end
            PH_WAIT_A, PH_WAIT_B:
            begin
                if (echo)
                begin
                    phase_next = (phase == PH_WAIT_A) ? PH_MEAS_A : PH_MEAS_B;
                    count_next = meas_cnt;
                    end_now    = meas_hit;
                end
                else
                begin
                    count_next = cnt_inc;
                    end_cm     = DIST_W'(CM_MAX);
                    end_now    = (CMP_W'(cnt_inc) >= CMP_W'(cfg.rise_timeout))
                                 || (cnt_inc == CNT_MAX);
                end
            end
            PH_MEAS_A, PH_MEAS_B:
            begin
                count_next = cnt_inc;
                end_now    = !echo || meas_hit;
            end
            default:
            begin
                phase_next = PH_IDLE;
                count_next = '0;
            end
        endcase

        if (end_now)
        begin
            count_next = '0;
            if (side_a)
            begin
                first_distance_next = end_cm;
                phase_next          = PH_TRIG_B;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    // result
    assign done = end_now && !side_a;
    assign comb = COMB_W'(first_distance * COMB_W'(CM_SCALE)) + COMB_W'(end_cm);

    always_comb
    begin
        res.trigger_a        = (phase_next == PH_TRIG_A);
        res.trigger_b        = (phase_next == PH_TRIG_B);
        res.busy_res         = (phase_next != PH_IDLE);
        res.done_res         = done;
        res.distance_a       = done ? first_distance : '0;
        res.distance_b       = done ? end_cm : '0;
        res.combined_reading = done ? comb : '0;
    end

endmodule

`default_nettype wire

### rtl/core/dual_ultrasonic_ranger.sv
// ----------------------------------------------------------------------------
// dual_ultrasonic_ranger
// Two-sensor echo-pulse ranger driven by a stream of 1 us ticks.
//
// Input stream s_*: one transaction per tick; s_tdata carries start_request,
// echo_a and echo_b. Output stream m_*: one transaction per input tick with
// trigger levels, busy, done and, on the done tick, both distances in cm and
// the combined reading distance_a*1000 + distance_b.
// Configuration: cfg_we with cfg_index 0/1/2 writes trigger_ticks,
// rise_timeout, fall_timeout; write only while no tick is in flight.
// Path: a tick in the input register goes through dur_step into the result
// register, which drives m_*. Throughput: one tick per cycle while not stalled;
// the phase/counter update is combinational logic between the two registers.
// Reset: phase idle, counter and stored distance cleared, registers at their
// defaults (10, 100000, 1000000), both stream stages empty.
// Stall: while m_tready is low the result holds; an empty input register still
// takes one more tick, after which s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_ultrasonic_ranger (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dur_pkg::IN_W-1:0]          s_tdata,   // start_request, echo_a, echo_b
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dur_pkg::OUT_W-1:0]         m_tdata,   // trigger_a, trigger_b, busy_res,
                                                         // done_res, distance_a[9:0],
                                                         // distance_b[9:0],
                                                         // combined_reading[19:0]
    input  logic                              cfg_we,
    input  logic [dur_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dur_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dur_pkg::*;

    logic                   in_valid_reg;
    dur_item_t              in_item_reg;
    logic                   out_valid_reg;
    dur_res_t               out_res_reg;
    dur_phase_t             phase_reg;
    dur_phase_t             phase_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [DIST_W-1:0]      first_reg;
    logic [DIST_W-1:0]      first_next;
    dur_cfg_t               cfg_reg;
    dur_res_t               res;
    logic                   advance;
    logic                   fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    dur_step u_step (
        .phase               (phase_reg),
        .count               (count_reg),
        .first_distance      (first_reg),
        .cfg                 (cfg_reg),
        .item                (in_item_reg),
        .phase_next          (phase_next),
        .count_next          (count_next),
        .first_distance_next (first_next),
        .res                 (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            first_reg     <= '0;
            cfg_reg       <= '{trigger_ticks: TRIG_RESET,
                               rise_timeout:  RISE_RESET,
                               fall_timeout:  FALL_RESET};
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (fire)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                first_reg <= first_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TRIGGER_TICKS: cfg_reg.trigger_ticks <= cfg_data[TRIG_W-1:0];
                    REG_RISE_TIMEOUT:  cfg_reg.rise_timeout  <= cfg_data[TIMEOUT_W-1:0];
                    REG_FALL_TIMEOUT:  cfg_reg.fall_timeout  <= cfg_data[TIMEOUT_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.start_request <= s_tdata[IN_START_BIT];
            in_item_reg.echo_a        <= s_tdata[IN_ECHO_A_BIT];
            in_item_reg.echo_b        <= s_tdata[IN_ECHO_B_BIT];
        end
        if (fire)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        m_tdata                          = '0;
        m_tdata[OUT_TRIG_A]              = out_res_reg.trigger_a;
        m_tdata[OUT_TRIG_B]              = out_res_reg.trigger_b;
        m_tdata[OUT_BUSY]                = out_res_reg.busy_res;
        m_tdata[OUT_DONE]                = out_res_reg.done_res;
        m_tdata[OUT_DIST_A +: DIST_W]    = out_res_reg.distance_a;
        m_tdata[OUT_DIST_B +: DIST_W]    = out_res_reg.distance_b;
        m_tdata[OUT_COMB +: COMB_W]      = out_res_reg.combined_reading;
    end

endmodule

`default_nettype wire

### rtl/core/dur_checker.sv
// ----------------------------------------------------------------------------
// dur_checker
// Port-level checks for the dual ultrasonic ranger, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dur_checker (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              m_tvalid,
    input  wire                              m_tready,
    input  wire [dur_pkg::OUT_W-1:0]         m_tdata
);
    import dur_pkg::*;

    logic [DIST_W-1:0] dist_a;
    logic [DIST_W-1:0] dist_b;
    logic [COMB_W-1:0] comb;

    assign dist_a    = m_tdata[OUT_DIST_A +: DIST_W];
    assign dist_b    = m_tdata[OUT_DIST_B +: DIST_W];
    assign comb      = m_tdata[OUT_COMB +: COMB_W];

    // done ends the sequence: never busy on that transaction
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OUT_DONE] |-> !m_tdata[OUT_BUSY])
        else $error("done with busy set");

    // only one trigger driven at a time
    a_one_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[OUT_TRIG_A] && m_tdata[OUT_TRIG_B]))
        else $error("both triggers high");

    // distance fields are zero outside the done transaction
    a_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[OUT_DONE] |-> (m_tdata[OUT_USED-1:OUT_DIST_A] == '0))
        else $error("distance fields set without done");

    // combined reading matches the two distances, both at most 999
    a_combined: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OUT_DONE] |->
            (COMB_W'(dist_a * COMB_W'(CM_SCALE)) + COMB_W'(dist_b) == comb)
            && (dist_a <= DIST_W'(CM_MAX)) && (dist_b <= DIST_W'(CM_MAX)))
        else $error("combined reading mismatch");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind dual_ultrasonic_ranger dur_checker u_dur_checker (.*);

`default_nettype wire
